// ----- design/afwr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afwr_pkg: shared types and constants of the audio frame word repacker
// Mode codes, register indexes, reset values and the beat / result-set
// structures passed between the conversion core and the output buffer.
// ----------------------------------------------------------------------------
package afwr_pkg;

    localparam int BYTE_W     = 8;
    localparam int UNIT_W     = 14;
    localparam int TAKEN_W    = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SET_DEPTH  = 4;
    localparam int SET_CNT_W  = 3;
    localparam int ACC_W      = 6;
    localparam int BCNT_W     = 3;

    // bytes the sync marker spans
    localparam logic [TAKEN_W-1:0] SYNC_BYTES = 16'd4;

    // register reset values
    localparam logic [TAKEN_W-1:0]    RST_MAX_BYTES      = 16'd16384;
    localparam logic [CFG_DATA_W-1:0] RST_SYNC_PLAIN_BE  = 32'h7FFE_8001;
    localparam logic [CFG_DATA_W-1:0] RST_SYNC_PLAIN_LE  = 32'hFE7F_0180;
    localparam logic [CFG_DATA_W-1:0] RST_SYNC_PACKED_BE = 32'h1FFF_E800;
    localparam logic [CFG_DATA_W-1:0] RST_SYNC_PACKED_LE = 32'hFF1F_00E8;
    localparam logic [CFG_DATA_W-1:0] RST_SYNC_EXTENSION = 32'h6458_2025;

    // conversion mode of the current frame
    typedef enum logic [2:0] {
        MODE_NONE    = 3'd0,
        MODE_PASS    = 3'd1,
        MODE_SWAP    = 3'd2,
        MODE_PACK_BE = 3'd3,
        MODE_PACK_LE = 3'd4
    } t_mode;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MAX_BYTES      = 3'd0,
        REG_SYNC_PLAIN_BE  = 3'd1,
        REG_SYNC_PLAIN_LE  = 3'd2,
        REG_SYNC_PACKED_BE = 3'd3,
        REG_SYNC_PACKED_LE = 3'd4,
        REG_SYNC_EXTENSION = 3'd5
    } t_cfg_reg;

    // one input beat
    typedef struct packed {
        logic              frame_end;
        logic              second_valid;
        logic [BYTE_W-1:0] second_byte;
        logic [BYTE_W-1:0] first_byte;
    } t_in_beat;

    // all results caused by one input beat
    typedef struct packed {
        logic [SET_DEPTH-1:0][BYTE_W-1:0] bytes;
        logic [SET_CNT_W-1:0]             count;
        logic                             last;
        logic                             status;
    } t_result_set;

endpackage

// ----- design/afwr_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afwr_core: input register, frame state and conversion logic
// Registers one beat, matches the sync marker, converts the unit and
// hands the resulting set of up to four bytes to the output buffer.
// ----------------------------------------------------------------------------
module afwr_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [afwr_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [afwr_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                               i_in_valid,
    input  afwr_pkg::t_in_beat                 i_in_beat,
    output logic                               o_in_ready,
    input  logic                               i_set_free,
    output logic                               o_set_load,
    output afwr_pkg::t_result_set              o_set
);

    typedef struct packed {
        logic [1:0]                       m;
        logic [afwr_pkg::BYTE_W-1:0]      b0;
        logic [afwr_pkg::BYTE_W-1:0]      b1;
        logic [afwr_pkg::ACC_W-1:0]       acc;
        logic [afwr_pkg::BCNT_W-1:0]      cnt;
    } t_unit_res;

    // convert one unit; pack modes append 14 bits to the bit carry
    function automatic t_unit_res proc_unit(
        input afwr_pkg::t_mode               mode,
        input logic [afwr_pkg::BYTE_W-1:0]   hi,
        input logic [afwr_pkg::BYTE_W-1:0]   lo,
        input logic [1:0]                    k,
        input logic [afwr_pkg::ACC_W-1:0]    acc,
        input logic [afwr_pkg::BCNT_W-1:0]   cnt
    );
        t_unit_res                     r;
        logic [afwr_pkg::UNIT_W-1:0]   v;
        r.m   = 2'd0;
        r.b0  = '0;
        r.b1  = '0;
        r.acc = acc;
        r.cnt = cnt;
        v     = (mode == afwr_pkg::MODE_PACK_BE) ? {hi[5:0], lo} : {lo[5:0], hi};
        unique case (mode)
            afwr_pkg::MODE_PASS: begin
                r.m  = k;
                r.b0 = hi;
                r.b1 = lo;
            end
            afwr_pkg::MODE_SWAP: begin
                r.m  = k;
                r.b0 = lo;
                r.b1 = hi;
            end
            afwr_pkg::MODE_PACK_BE, afwr_pkg::MODE_PACK_LE: begin
                if (k != 2'd0) begin
                    // carry holds 0, 2, 4 or 6 bits
                    unique case (cnt)
                        3'd2: begin
                            r.m   = 2'd2;
                            r.b0  = {acc[1:0], v[13:8]};
                            r.b1  = v[7:0];
                            r.acc = '0;
                            r.cnt = 3'd0;
                        end
                        3'd4: begin
                            r.m   = 2'd2;
                            r.b0  = {acc[3:0], v[13:10]};
                            r.b1  = v[9:2];
                            r.acc = {4'b0, v[1:0]};
                            r.cnt = 3'd2;
                        end
                        3'd6: begin
                            r.m   = 2'd2;
                            r.b0  = {acc[5:0], v[13:12]};
                            r.b1  = v[11:4];
                            r.acc = {2'b0, v[3:0]};
                            r.cnt = 3'd4;
                        end
                        default: begin
                            r.m   = 2'd1;
                            r.b0  = v[13:6];
                            r.acc = v[5:0];
                            r.cnt = 3'd6;
                        end
                    endcase
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // configuration registers
    logic [afwr_pkg::TAKEN_W-1:0]    r_max_bytes;
    logic [afwr_pkg::CFG_DATA_W-1:0] r_sync_plain_be;
    logic [afwr_pkg::CFG_DATA_W-1:0] r_sync_plain_le;
    logic [afwr_pkg::CFG_DATA_W-1:0] r_sync_packed_be;
    logic [afwr_pkg::CFG_DATA_W-1:0] r_sync_packed_le;
    logic [afwr_pkg::CFG_DATA_W-1:0] r_sync_extension;

    // input register
    logic                 r_in_valid;
    afwr_pkg::t_in_beat   r_in;
    logic                 w_take;

    // frame state
    afwr_pkg::t_mode                r_conv_mode,   n_conv_mode;
    logic [15:0]                    r_held_unit,   n_held_unit;
    logic                           r_held_valid,  n_held_valid;
    logic [afwr_pkg::ACC_W-1:0]     r_bit_accum,   n_bit_accum;
    logic [afwr_pkg::BCNT_W-1:0]    r_bit_count,   n_bit_count;
    logic [afwr_pkg::TAKEN_W-1:0]   r_bytes_taken, n_bytes_taken;
    logic                           r_frame_done,  n_frame_done;

    // front end
    logic                           w_t1, w_t2, w_end;
    logic [afwr_pkg::TAKEN_W-1:0]   w_taken1, w_taken2;
    logic [afwr_pkg::BYTE_W-1:0]    w_a, w_b;
    logic [1:0]                     w_k;
    logic [31:0]                    w_mark;
    afwr_pkg::t_mode                w_match, w_mode;

    // decision
    logic w_hold, w_err, w_decide, w_proc_cur;

    // data path
    t_unit_res                      w_u0, w_u1;
    logic [afwr_pkg::ACC_W-1:0]     w_acc1;
    logic [afwr_pkg::BCNT_W-1:0]    w_cnt1;
    logic                           w_pad_en;
    logic [afwr_pkg::BYTE_W-1:0]    w_pad_byte;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes      <= afwr_pkg::RST_MAX_BYTES;
            r_sync_plain_be  <= afwr_pkg::RST_SYNC_PLAIN_BE;
            r_sync_plain_le  <= afwr_pkg::RST_SYNC_PLAIN_LE;
            r_sync_packed_be <= afwr_pkg::RST_SYNC_PACKED_BE;
            r_sync_packed_le <= afwr_pkg::RST_SYNC_PACKED_LE;
            r_sync_extension <= afwr_pkg::RST_SYNC_EXTENSION;
        end else if (i_cfg_we) begin
            unique case (afwr_pkg::t_cfg_reg'(i_cfg_addr))
                afwr_pkg::REG_MAX_BYTES:      r_max_bytes      <= i_cfg_wdata[15:0];
                afwr_pkg::REG_SYNC_PLAIN_BE:  r_sync_plain_be  <= i_cfg_wdata;
                afwr_pkg::REG_SYNC_PLAIN_LE:  r_sync_plain_le  <= i_cfg_wdata;
                afwr_pkg::REG_SYNC_PACKED_BE: r_sync_packed_be <= i_cfg_wdata;
                afwr_pkg::REG_SYNC_PACKED_LE: r_sync_packed_le <= i_cfg_wdata;
                afwr_pkg::REG_SYNC_EXTENSION: r_sync_extension <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register: refills when empty or whenever the held beat moves on
    assign w_take     = r_in_valid && i_set_free;
    assign o_in_ready = !r_in_valid || i_set_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_beat;
        end
    end

    // byte limit and marker match
    always_comb begin
        w_t1     = r_bytes_taken < r_max_bytes;
        w_taken1 = r_bytes_taken + {15'b0, w_t1};
        w_t2     = w_t1 && r_in.second_valid && (w_taken1 < r_max_bytes);
        w_taken2 = w_taken1 + {15'b0, w_t2};
        w_a      = w_t1 ? r_in.first_byte : 8'h00;
        w_b      = w_t2 ? r_in.second_byte : 8'h00;
        w_k      = {1'b0, w_t1} + {1'b0, w_t2};
        w_end    = r_in.frame_end || (w_taken2 >= r_max_bytes);
        w_mark   = {r_held_unit, w_a, w_b};
        priority if (w_taken2 < afwr_pkg::SYNC_BYTES) begin
            w_match = afwr_pkg::MODE_NONE;
        end else if (w_mark == r_sync_plain_be || w_mark == r_sync_extension) begin
            w_match = afwr_pkg::MODE_PASS;
        end else if (w_mark == r_sync_plain_le) begin
            w_match = afwr_pkg::MODE_SWAP;
        end else if (w_mark == r_sync_packed_be) begin
            w_match = afwr_pkg::MODE_PACK_BE;
        end else if (w_mark == r_sync_packed_le) begin
            w_match = afwr_pkg::MODE_PACK_LE;
        end else begin
            w_match = afwr_pkg::MODE_NONE;
        end
        w_mode = (r_conv_mode == afwr_pkg::MODE_NONE) ? w_match : r_conv_mode;
    end

    // what this beat does to the frame
    always_comb begin
        w_hold     = 1'b0;
        w_err      = 1'b0;
        w_decide   = 1'b0;
        w_proc_cur = 1'b0;
        if (!r_frame_done) begin
            if (r_conv_mode == afwr_pkg::MODE_NONE) begin
                if (!r_held_valid) begin
                    if (w_k != 2'd0 && !w_end) begin
                        w_hold = 1'b1;
                    end else begin
                        w_err = 1'b1;
                    end
                end else if (w_match == afwr_pkg::MODE_NONE) begin
                    w_err = 1'b1;
                end else begin
                    w_decide   = 1'b1;
                    w_proc_cur = 1'b1;
                end
            end else begin
                w_proc_cur = 1'b1;
            end
        end
    end

    // conversion of held and current unit, tail padding
    always_comb begin
        w_u0   = proc_unit(w_mode, r_held_unit[15:8], r_held_unit[7:0], 2'd2,
                           r_bit_accum, r_bit_count);
        w_acc1 = w_decide ? w_u0.acc : r_bit_accum;
        w_cnt1 = w_decide ? w_u0.cnt : r_bit_count;
        w_u1   = proc_unit(w_mode, w_a, w_b, w_k, w_acc1, w_cnt1);
        w_pad_en = w_end && w_u1.cnt != 3'd0 &&
                   (w_mode == afwr_pkg::MODE_PACK_BE || w_mode == afwr_pkg::MODE_PACK_LE);
        unique case (w_u1.cnt)
            3'd2:    w_pad_byte = {w_u1.acc[1:0], 6'b0};
            3'd4:    w_pad_byte = {w_u1.acc[3:0], 4'b0};
            3'd6:    w_pad_byte = {w_u1.acc[5:0], 2'b0};
            default: w_pad_byte = 8'h00;
        endcase
    end

    // result set assembly
    always_comb begin
        logic [4:0][afwr_pkg::BYTE_W-1:0] cand;
        logic [4:0]                       cand_en;
        logic [afwr_pkg::SET_CNT_W-1:0]   cnt;
        cand    = {w_pad_byte, w_u1.b1, w_u1.b0, w_u0.b1, w_u0.b0};
        cand_en = {w_proc_cur && w_pad_en,
                   w_proc_cur && w_u1.m == 2'd2,
                   w_proc_cur && w_u1.m != 2'd0,
                   w_decide && w_u0.m == 2'd2,
                   w_decide && w_u0.m != 2'd0};
        cnt     = '0;
        o_set   = '0;
        for (int i = 0; i < 5; i++) begin
            if (cand_en[i] && cnt != 3'd4) begin
                o_set.bytes[cnt[1:0]] = cand[i];
                cnt                   = cnt + 3'd1;
            end
        end
        o_set.count = cnt;
        if (w_err) begin
            o_set.bytes  = '0;
            o_set.count  = 3'd1;
            o_set.last   = 1'b1;
            o_set.status = 1'b1;
        end else if (w_proc_cur && w_end) begin
            o_set.last = 1'b1;
            // frame ended on a beat that produced nothing
            if (cnt == 3'd0) begin
                o_set.count = 3'd1;
            end
        end
    end

    assign o_set_load = w_take;

    // next frame state
    always_comb begin
        n_conv_mode   = r_conv_mode;
        n_held_unit   = r_held_unit;
        n_held_valid  = r_held_valid;
        n_bit_accum   = r_bit_accum;
        n_bit_count   = r_bit_count;
        n_bytes_taken = r_bytes_taken;
        n_frame_done  = r_frame_done;
        if (w_take) begin
            if (w_hold) begin
                n_held_unit   = {w_a, w_b};
                n_held_valid  = 1'b1;
                n_bytes_taken = w_taken2;
            end else if (w_proc_cur) begin
                n_conv_mode   = w_mode;
                n_held_unit   = '0;
                n_held_valid  = 1'b0;
                n_bit_accum   = w_end ? '0 : w_u1.acc;
                n_bit_count   = w_end ? '0 : w_u1.cnt;
                n_bytes_taken = w_taken2;
            end
            // frame closes: start fresh on frame_end, else drop until it
            if (r_frame_done || w_err || (w_proc_cur && w_end)) begin
                if (r_in.frame_end) begin
                    n_conv_mode   = afwr_pkg::MODE_NONE;
                    n_held_unit   = '0;
                    n_held_valid  = 1'b0;
                    n_bit_accum   = '0;
                    n_bit_count   = '0;
                    n_bytes_taken = '0;
                    n_frame_done  = 1'b0;
                end else begin
                    n_frame_done  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv_mode   <= afwr_pkg::MODE_NONE;
            r_held_unit   <= '0;
            r_held_valid  <= 1'b0;
            r_bit_accum   <= '0;
            r_bit_count   <= '0;
            r_bytes_taken <= '0;
            r_frame_done  <= 1'b0;
        end else begin
            r_conv_mode   <= n_conv_mode;
            r_held_unit   <= n_held_unit;
            r_held_valid  <= n_held_valid;
            r_bit_accum   <= n_bit_accum;
            r_bit_count   <= n_bit_count;
            r_bytes_taken <= n_bytes_taken;
            r_frame_done  <= n_frame_done;
        end
    end

`ifndef ASSERT_OFF
    // packing carry always holds an even number of bits
    a_carry_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count[0] == 1'b0)
        else $error("packing carry count is odd");

    // a held first unit exists only before the mode is decided
    a_held_undecided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> r_conv_mode == afwr_pkg::MODE_NONE)
        else $error("held unit with decided mode");

    // the end of a frame always carries at least one result
    a_last_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_set_load && o_set.last) |-> o_set.count != 3'd0)
        else $error("frame end without result");
`endif

endmodule

// ----- design/afwr_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afwr_out_buf: result register and byte serializer
// Holds one result set and sends its bytes one beat at a time; frees
// itself for the next set in the cycle its final beat is taken.
// ----------------------------------------------------------------------------
module afwr_out_buf (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  afwr_pkg::t_result_set           i_set,
    output logic                            o_free,
    output logic                            o_m_tvalid,
    output logic [afwr_pkg::BYTE_W-1:0]     o_m_tdata,
    output logic                            o_m_tlast,
    output logic                            o_m_tuser,
    input  logic                            i_m_tready
);

    logic [afwr_pkg::SET_DEPTH-1:0][afwr_pkg::BYTE_W-1:0] r_bytes;
    logic [afwr_pkg::SET_CNT_W-1:0]                        r_rem, n_rem;
    logic                                                  r_last;
    logic                                                  r_status;
    logic                                                  w_fire;

    assign o_m_tvalid = r_rem != '0;
    assign w_fire     = o_m_tvalid && i_m_tready;
    assign o_free     = (r_rem == 3'd0) || (r_rem == 3'd1 && i_m_tready);
    assign o_m_tdata  = r_bytes[0];
    assign o_m_tlast  = r_last && r_rem == 3'd1;
    assign o_m_tuser  = r_status;

    // remaining beat count
    always_comb begin
        priority if (i_load) begin
            n_rem = i_set.count;
        end else if (w_fire) begin
            n_rem = r_rem - 3'd1;
        end else begin
            n_rem = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

    // payload: load a new set or shift toward the head
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes  <= i_set.bytes;
            r_last   <= i_set.last;
            r_status <= i_set.status;
        end else if (w_fire) begin
            r_bytes  <= {8'h00, r_bytes[afwr_pkg::SET_DEPTH-1:1]};
        end
    end

`ifndef ASSERT_OFF
    // never more beats pending than a set can hold
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= 3'd4)
        else $error("result count overflow");

    // a new set never overwrites beats still pending
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_rem == 3'd0 || (r_rem == 3'd1 && w_fire)))
        else $error("result set overwritten");
`endif

endmodule

// ----- design/audio_frame_word_repacker.sv -----
`timescale 1ns / 1ps
// A result byte passes the input register and then the result register on its way
// to the output; the input register holds its beat while the result register is busy.
// A beat holds the output side until all bytes it yields (1 to 4) are sent, and not at
// all when it yields none; the serial result register, one byte per beat, sets the pace.
// Reset (synchronous, active low) clears frame state and loads register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// audio_frame_word_repacker: frame sync detect and 14/16-bit word repacking
// Matches the first 32 frame bits against five sync markers and passes,
// byte swaps or 14-bit packs the two-byte units of the frame.
// ----------------------------------------------------------------------------
module audio_frame_word_repacker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [afwr_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [afwr_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // input stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [15:0]                        i_s_axis_tdata,  // first_byte, second_byte
    input  logic                               i_s_axis_tuser,  // second_valid
    input  logic                               i_s_axis_tlast,  // frame_end
    // output stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [afwr_pkg::BYTE_W-1:0]        o_m_axis_tdata,  // out_byte
    output logic                               o_m_axis_tuser,  // status
    output logic                               o_m_axis_tlast   // out_last
);

    afwr_pkg::t_in_beat     w_in_beat;
    afwr_pkg::t_result_set  w_set;
    logic                   w_set_load;
    logic                   w_set_free;

    // unpack the input beat
    assign w_in_beat.first_byte   = i_s_axis_tdata[7:0];
    assign w_in_beat.second_byte  = i_s_axis_tdata[15:8];
    assign w_in_beat.second_valid = i_s_axis_tuser;
    assign w_in_beat.frame_end    = i_s_axis_tlast;

    afwr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_beat   (w_in_beat),
        .o_in_ready  (o_s_axis_tready),
        .i_set_free  (w_set_free),
        .o_set_load  (w_set_load),
        .o_set       (w_set)
    );

    afwr_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_set_load),
        .i_set      (w_set),
        .o_free     (w_set_free),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast),
        .o_m_tuser  (o_m_axis_tuser),
        .i_m_tready (i_m_axis_tready)
    );

endmodule
